FILE: hdl/des_round_function_defines.svh
// ---------------------------------------------------------------------------
// DES round function assertion macros
// Clocked assertion wrappers used by the round function RTL.
// ---------------------------------------------------------------------------
`ifndef DES_ROUND_FUNCTION_DEFINES_SVH
`define DES_ROUND_FUNCTION_DEFINES_SVH

`ifndef NO_ASSERTIONS

// A property checked at every rising clock edge outside reset.
`define DRF_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// An implication checked at every rising clock edge outside reset.
`define DRF_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// A next-cycle implication checked outside reset.
`define DRF_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`else

`define DRF_ASSERT(lbl, prop, msg)
`define DRF_ASSERT_IMP(lbl, ante, cons, msg)
`define DRF_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

FILE: hdl/drf_pkg.sv
// ---------------------------------------------------------------------------
// DES round function package
// Widths, the E and P permutation tables, the S-boxes and helper functions.
// ---------------------------------------------------------------------------
package drf_pkg;

   localparam int HALF_W = 32;
   localparam int KEY_W  = 48;
   localparam int NUM_BOXES = 8;

   typedef logic [HALF_W-1:0] half_type;
   typedef logic [KEY_W-1:0]  key_type;

   // Table entries use DES numbering: bit 1 is the most significant bit.
   localparam logic [5:0] E_TAB [0:47] = '{
      6'd32, 6'd1,  6'd2,  6'd3,  6'd4,  6'd5,  6'd4,  6'd5,  6'd6,  6'd7,  6'd8,  6'd9,
      6'd8,  6'd9,  6'd10, 6'd11, 6'd12, 6'd13, 6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17,
      6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21, 6'd20, 6'd21, 6'd22, 6'd23, 6'd24, 6'd25,
      6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29, 6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd1
   };

   localparam logic [5:0] P_TAB [0:31] = '{
      6'd16, 6'd7,  6'd20, 6'd21, 6'd29, 6'd12, 6'd28, 6'd17,
      6'd1,  6'd15, 6'd23, 6'd26, 6'd5,  6'd18, 6'd31, 6'd10,
      6'd2,  6'd8,  6'd24, 6'd14, 6'd32, 6'd27, 6'd3,  6'd9,
      6'd19, 6'd13, 6'd30, 6'd6,  6'd22, 6'd11, 6'd4,  6'd25
   };

   // Each box is stored row after row: entry index is row * 16 + column.
   localparam logic [3:0] SBOX_TAB [0:NUM_BOXES-1][0:63] = '{
      '{4'd14,4'd4,4'd13,4'd1,4'd2,4'd15,4'd11,4'd8,4'd3,4'd10,4'd6,4'd12,4'd5,4'd9,4'd0,4'd7,
        4'd0,4'd15,4'd7,4'd4,4'd14,4'd2,4'd13,4'd1,4'd10,4'd6,4'd12,4'd11,4'd9,4'd5,4'd3,4'd8,
        4'd4,4'd1,4'd14,4'd8,4'd13,4'd6,4'd2,4'd11,4'd15,4'd12,4'd9,4'd7,4'd3,4'd10,4'd5,4'd0,
        4'd15,4'd12,4'd8,4'd2,4'd4,4'd9,4'd1,4'd7,4'd5,4'd11,4'd3,4'd14,4'd10,4'd0,4'd6,4'd13},
      '{4'd15,4'd1,4'd8,4'd14,4'd6,4'd11,4'd3,4'd4,4'd9,4'd7,4'd2,4'd13,4'd12,4'd0,4'd5,4'd10,
        4'd3,4'd13,4'd4,4'd7,4'd15,4'd2,4'd8,4'd14,4'd12,4'd0,4'd1,4'd10,4'd6,4'd9,4'd11,4'd5,
        4'd0,4'd14,4'd7,4'd11,4'd10,4'd4,4'd13,4'd1,4'd5,4'd8,4'd12,4'd6,4'd9,4'd3,4'd2,4'd15,
        4'd13,4'd8,4'd10,4'd1,4'd3,4'd15,4'd4,4'd2,4'd11,4'd6,4'd7,4'd12,4'd0,4'd5,4'd14,4'd9},
      '{4'd10,4'd0,4'd9,4'd14,4'd6,4'd3,4'd15,4'd5,4'd1,4'd13,4'd12,4'd7,4'd11,4'd4,4'd2,4'd8,
        4'd13,4'd7,4'd0,4'd9,4'd3,4'd4,4'd6,4'd10,4'd2,4'd8,4'd5,4'd14,4'd12,4'd11,4'd15,4'd1,
        4'd13,4'd6,4'd4,4'd9,4'd8,4'd15,4'd3,4'd0,4'd11,4'd1,4'd2,4'd12,4'd5,4'd10,4'd14,4'd7,
        4'd1,4'd10,4'd13,4'd0,4'd6,4'd9,4'd8,4'd7,4'd4,4'd15,4'd14,4'd3,4'd11,4'd5,4'd2,4'd12},
      '{4'd7,4'd13,4'd14,4'd3,4'd0,4'd6,4'd9,4'd10,4'd1,4'd2,4'd8,4'd5,4'd11,4'd12,4'd4,4'd15,
        4'd13,4'd8,4'd11,4'd5,4'd6,4'd15,4'd0,4'd3,4'd4,4'd7,4'd2,4'd12,4'd1,4'd10,4'd14,4'd9,
        4'd10,4'd6,4'd9,4'd0,4'd12,4'd11,4'd7,4'd13,4'd15,4'd1,4'd3,4'd14,4'd5,4'd2,4'd8,4'd4,
        4'd3,4'd15,4'd0,4'd6,4'd10,4'd1,4'd13,4'd8,4'd9,4'd4,4'd5,4'd11,4'd12,4'd7,4'd2,4'd14},
      '{4'd2,4'd12,4'd4,4'd1,4'd7,4'd10,4'd11,4'd6,4'd8,4'd5,4'd3,4'd15,4'd13,4'd0,4'd14,4'd9,
        4'd14,4'd11,4'd2,4'd12,4'd4,4'd7,4'd13,4'd1,4'd5,4'd0,4'd15,4'd10,4'd3,4'd9,4'd8,4'd6,
        4'd4,4'd2,4'd1,4'd11,4'd10,4'd13,4'd7,4'd8,4'd15,4'd9,4'd12,4'd5,4'd6,4'd3,4'd0,4'd14,
        4'd11,4'd8,4'd12,4'd7,4'd1,4'd14,4'd2,4'd13,4'd6,4'd15,4'd0,4'd9,4'd10,4'd4,4'd5,4'd3},
      '{4'd12,4'd1,4'd10,4'd15,4'd9,4'd2,4'd6,4'd8,4'd0,4'd13,4'd3,4'd4,4'd14,4'd7,4'd5,4'd11,
        4'd10,4'd15,4'd4,4'd2,4'd7,4'd12,4'd9,4'd5,4'd6,4'd1,4'd13,4'd14,4'd0,4'd11,4'd3,4'd8,
        4'd9,4'd14,4'd15,4'd5,4'd2,4'd8,4'd12,4'd3,4'd7,4'd0,4'd4,4'd10,4'd1,4'd13,4'd11,4'd6,
        4'd4,4'd3,4'd2,4'd12,4'd9,4'd5,4'd15,4'd10,4'd11,4'd14,4'd1,4'd7,4'd6,4'd0,4'd8,4'd13},
      '{4'd4,4'd11,4'd2,4'd14,4'd15,4'd0,4'd8,4'd13,4'd3,4'd12,4'd9,4'd7,4'd5,4'd10,4'd6,4'd1,
        4'd13,4'd0,4'd11,4'd7,4'd4,4'd9,4'd1,4'd10,4'd14,4'd3,4'd5,4'd12,4'd2,4'd15,4'd8,4'd6,
        4'd1,4'd4,4'd11,4'd13,4'd12,4'd3,4'd7,4'd14,4'd10,4'd15,4'd6,4'd8,4'd0,4'd5,4'd9,4'd2,
        4'd6,4'd11,4'd13,4'd8,4'd1,4'd4,4'd10,4'd7,4'd9,4'd5,4'd0,4'd15,4'd14,4'd2,4'd3,4'd12},
      '{4'd13,4'd2,4'd8,4'd4,4'd6,4'd15,4'd11,4'd1,4'd10,4'd9,4'd3,4'd14,4'd5,4'd0,4'd12,4'd7,
        4'd1,4'd15,4'd13,4'd8,4'd10,4'd3,4'd7,4'd4,4'd12,4'd5,4'd6,4'd11,4'd0,4'd14,4'd9,4'd2,
        4'd7,4'd11,4'd4,4'd1,4'd9,4'd12,4'd14,4'd2,4'd0,4'd6,4'd10,4'd13,4'd15,4'd3,4'd5,4'd8,
        4'd2,4'd1,4'd14,4'd7,4'd4,4'd10,4'd8,4'd13,4'd15,4'd12,4'd9,4'd0,4'd3,4'd5,4'd6,4'd11}
   };

   // E expansion: output DES bit i+1 takes input DES bit E_TAB[i].
   function automatic key_type e_expand(input half_type r);
      key_type     x;
      logic [4:0]  idx;
      x = '0;
      for (int i = 0; i < KEY_W; i++) begin
         idx = 5'(HALF_W - int'(E_TAB[i]));
         x[KEY_W-1-i] = r[idx];
      end
      return x;
   endfunction

   // P permutation over the 32 S-box output bits.
   function automatic half_type p_permute(input half_type s);
      half_type    f;
      logic [4:0]  idx;
      f = '0;
      for (int i = 0; i < HALF_W; i++) begin
         idx = 5'(HALF_W - int'(P_TAB[i]));
         f[HALF_W-1-i] = s[idx];
      end
      return f;
   endfunction

endpackage

FILE: hdl/des_round_function.sv
// ---------------------------------------------------------------------------
// DES round function
// Computes f(R, K) = P(S(E(R) xor K)) in a three-stage pipeline.
// ---------------------------------------------------------------------------
// Usage:
//   The request channel carries one word per item: the 32-bit right half
//   (req_right_half) and the 48-bit round key (req_round_key). The response
//   channel returns one word, the 32-bit f value (rsp_f_value), per request,
//   in request order. Both channels use a valid/ready handshake.
//   Stage one registers the expanded half xor key, stage two the S-box
//   outputs and stage three the P permutation, which is also the output
//   register behind rsp_valid.
//   Throughput is one word per cycle while the receiver takes responses;
//   the S-box lookup stage sets the clock period.
//   When the receiver stalls, each stage holds its word and an empty stage
//   still takes the word behind it, so up to three words wait in the block
//   before req_ready drops. A synchronous reset empties the pipeline.
// ---------------------------------------------------------------------------
`include "des_round_function_defines.svh"

module des_round_function (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  drf_pkg::half_type req_right_half,
   input  drf_pkg::key_type  req_round_key,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output drf_pkg::half_type rsp_f_value
);
   import drf_pkg::*;

   logic     s1_valid_ff, s1_valid_in;
   logic     s2_valid_ff, s2_valid_in;
   logic     s3_valid_ff, s3_valid_in;
   key_type  s1_mix_ff,   s1_mix_in;
   half_type s2_sub_ff,   s2_sub_in;
   half_type s3_f_ff,     s3_f_in;
   logic     s1_ready, s2_ready, s3_ready;

   // A stage can load when it is empty or its word moves on this cycle.
   assign s3_ready = !s3_valid_ff || rsp_ready;
   assign s2_ready = !s2_valid_ff || s3_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;

   drf_sbox_bank u_sbox (
      .mixed (s1_mix_ff),
      .subst (s2_sub_in)
   );

   always_comb begin
      s1_valid_in = s1_ready ? req_valid   : s1_valid_ff;
      s2_valid_in = s2_ready ? s1_valid_ff : s2_valid_ff;
      s3_valid_in = s3_ready ? s2_valid_ff : s3_valid_ff;
      s1_mix_in   = e_expand(req_right_half) ^ req_round_key;
      s3_f_in     = p_permute(s2_sub_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_mix_ff <= s1_mix_in;
      end
      if (s2_ready) begin
         s2_sub_ff <= s2_sub_in;
      end
      if (s3_ready) begin
         s3_f_ff <= s3_f_in;
      end
   end

   assign req_ready   = s1_ready;
   assign rsp_valid   = s3_valid_ff;
   assign rsp_f_value = s3_f_ff;

   `DRF_ASSERT_IMP(a_full_when_blocked, !req_ready,
      s1_valid_ff && s2_valid_ff && s3_valid_ff && !rsp_ready,
      "Request side blocked while the pipeline has room.")
   `DRF_ASSERT_NEXT(a_s2_holds, s2_valid_ff && !s3_ready,
      s2_valid_ff && $stable(s2_sub_ff), "Stalled S-box stage lost or changed its word.")
   `DRF_ASSERT_NEXT(a_s1_advances, s1_valid_ff && s2_ready,
      s2_valid_ff, "Word leaving the first stage did not reach the second.")
   `DRF_ASSERT_NEXT(a_s3_advances, s2_valid_ff && s3_ready,
      s3_valid_ff && (s3_f_ff == p_permute($past(s2_sub_ff))),
      "Output stage does not hold the permuted S-box word.")

endmodule

FILE: hdl/drf_sbox_bank.sv
// ---------------------------------------------------------------------------
// DES S-box bank
// Substitutes the eight 6-bit groups of a 48-bit word through S1 to S8.
// ---------------------------------------------------------------------------
module drf_sbox_bank (
   input  drf_pkg::key_type  mixed,
   output drf_pkg::half_type subst
);
   import drf_pkg::*;

   always_comb begin
      logic [5:0] grp;
      logic [5:0] addr;
      subst = '0;
      for (int b = 0; b < NUM_BOXES; b++) begin
         grp  = mixed[KEY_W-1-6*b -: 6];
         // The outer bits select the row, the inner four the column.
         addr = {grp[5], grp[0], grp[4:1]};
         subst[HALF_W-1-4*b -: 4] = SBOX_TAB[b][addr];
      end
   end

endmodule

FILE: test/des_round_function_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// DES round function testbench
// Sends right half and round key words through the request channel, predicts
// f = P(S(E(R) xor K)) for each accepted word and compares every response
// word in order against that prediction, with random idling on both sides.
// ---------------------------------------------------------------------------
module des_round_function_test;

   import drf_pkg::*;

   localparam int STALL_LIMIT  = 200;
   localparam int DRAIN_CYCLES = 10;
   localparam int RANDOM_WORDS = 500;
   localparam int MAX_PRINTS   = 20;

   // P permutation in DES numbering: result bit i+1 takes S-box bit P_SEL[i].
   localparam int P_SEL [0:31] = '{
      16, 7, 20, 21, 29, 12, 28, 17, 1, 15, 23, 26, 5, 18, 31, 10,
      2, 8, 24, 14, 32, 27, 3, 9, 19, 13, 30, 6, 22, 11, 4, 25
   };

   // One entry per S-box row (box * 4 + row); column 0 is the top nibble.
   localparam logic [63:0] SBOX_ROW [0:31] = '{
      64'hE4D12FB83A6C5907, 64'h0F74E2D1A6CB9538, 64'h41E8D62BFC973A50, 64'hFC8249175B3EA06D,
      64'hF18E6B34972DC05A, 64'h3D47F28EC01A69B5, 64'h0E7BA4D158C6932F, 64'hD8A13F42B67C05E9,
      64'hA09E63F51DC7B428, 64'hD709346A285ECBF1, 64'hD6498F30B12C5AE7, 64'h1AD069874FE3B52C,
      64'h7DE3069A1285BC4F, 64'hD8B56F03472C1AE9, 64'hA690CB7DF13E5284, 64'h3F06A1D8945BC72E,
      64'h2C417AB6853FD0E9, 64'hEB2C47D150FA3986, 64'h421BAD78F9C5630E, 64'hB8C71E2D6F09A453,
      64'hC1AF92680D34E75B, 64'hAF427C9561DE0B38, 64'h9EF528C3704A1DB6, 64'h432C95FABE17608D,
      64'h4B2EF08D3C975A61, 64'hD0B7491AE35C2F86, 64'h14BDC37EAF680592, 64'h6BD814A7950FE23C,
      64'hD2846FB1A93E50C7, 64'h1FD8A374C56B0E92, 64'h7B419CE206ADF358, 64'h21E74A8DFC90356B
   };

   typedef struct {
      half_type right;
      key_type  key;
      half_type f_value;
   } f_case_type;

   logic     clock;
   logic     reset;
   logic     req_valid;
   logic     req_ready;
   half_type req_right_half;
   key_type  req_round_key;
   logic     rsp_valid;
   logic     rsp_ready;
   half_type rsp_f_value;

   f_case_type expected_f [$];
   int       mismatch_count = 0;
   int       stall_cycles = 0;
   bit       send_gaps = 1'b1;
   bit       recv_gaps = 1'b1;

   des_round_function dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_right_half (req_right_half),
      .req_round_key  (req_round_key),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_f_value    (rsp_f_value)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic half_type des_f(input half_type right, input key_type key);
      key_type    xk;
      logic [5:0] grp;
      logic [1:0] row;
      logic [3:0] col;
      logic [63:0] row_word;
      half_type   sbits;
      half_type   fv;
      int         pos;
      // Expansion group g reads DES bits 4g .. 4g+5 of the half, wrapping around.
      for (int g = 0; g < 8; g++) begin
         for (int j = 0; j < 6; j++) begin
            pos = (4 * g + j + 31) % 32 + 1;
            xk[47 - 6 * g - j] = right[32 - pos];
         end
      end
      xk = xk ^ key;
      for (int g = 0; g < 8; g++) begin
         grp = xk[47 - 6 * g -: 6];
         row = {grp[5], grp[0]};
         col = grp[4:1];
         row_word = SBOX_ROW[4 * g + int'(row)];
         sbits[31 - 4 * g -: 4] = row_word[63 - 4 * int'(col) -: 4];
      end
      for (int i = 0; i < 32; i++) begin
         fv[31 - i] = sbits[32 - P_SEL[i]];
      end
      return fv;
   endfunction

   // Mostly uniform values, with the all-zero and all-one words mixed in.
   function automatic half_type pick_half();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return half_type'($urandom);
      endcase
   endfunction

   function automatic key_type pick_key();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return {16'($urandom), 32'($urandom)};
      endcase
   endfunction

   task automatic report_mismatch(input string what);
      if (mismatch_count < MAX_PRINTS) begin
         $display("ERROR at %0t: %s", $realtime, what);
      end
      mismatch_count++;
   endtask

   task automatic send_word(input half_type right, input key_type key);
      f_case_type c;
      int      gap;
      gap = send_gaps ? $urandom_range(0, 4) : 0;
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid      <= 1'b1;
      req_right_half <= right;
      req_round_key  <= key;
      @(posedge clock);
      while (!(req_valid && req_ready)) @(posedge clock);
      c.right   = right;
      c.key     = key;
      c.f_value = des_f(right, key);
      expected_f.push_back(c);
   endtask

   task automatic test_corner_words();
      send_gaps = 1'b1;
      recv_gaps = 1'b1;
      send_word('0, '0);
      send_word('1, '1);
      send_word('0, '1);
      send_word('1, '0);
      send_word(32'hAAAA_AAAA, 48'hAAAA_AAAA_AAAA);
      send_word(32'h5555_5555, 48'h5555_5555_5555);
      send_word(32'hAAAA_AAAA, 48'h5555_5555_5555);
      // First and last half bits each feed two expansion positions.
      send_word(32'h8000_0000, '0);
      send_word(32'h0000_0001, '0);
      send_word('0, 48'h8000_0000_0000);
      send_word('0, 48'h0000_0000_0001);
      send_word(32'hF0AA_F0AA, 48'h1B02_EFFC_7072);
      send_word(32'h0123_4567, 48'h89AB_CDEF_0123);
      send_word(32'hFEDC_BA98, 48'h7654_3210_FEDC);
   endtask

   // Sender never idles while the receiver stalls, so the pipeline fills up.
   task automatic test_pipeline_fill();
      send_gaps = 1'b0;
      recv_gaps = 1'b1;
      repeat (40) send_word(pick_half(), pick_key());
   endtask

   task automatic test_random_words();
      for (int seg = 0; seg < 10; seg++) begin
         send_gaps = (seg % 3 != 0);
         recv_gaps = (seg % 4 != 1);
         repeat (RANDOM_WORDS / 10) send_word(pick_half(), pick_key());
      end
      send_gaps = 1'b1;
      recv_gaps = 1'b1;
   endtask

   initial begin
      int stall;
      rsp_ready = 1'b0;
      forever begin
         stall = recv_gaps ? $urandom_range(0, 4) : 0;
         repeat (stall) begin
            @(negedge clock);
            rsp_ready <= 1'b0;
         end
         @(negedge clock);
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!(rsp_valid && rsp_ready)) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      f_case_type c;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_f.size() == 0) begin
            report_mismatch($sformatf("response word %h with nothing pending", rsp_f_value));
         end else begin
            c = expected_f.pop_front();
            if (rsp_f_value !== c.f_value) begin
               report_mismatch($sformatf("R=%h K=%h: f=%h, predicted %h",
                  c.right, c.key, rsp_f_value, c.f_value));
            end
         end
      end
   end

   // Counts cycles in which work is pending but no word moves on either side.
   always @(posedge clock) begin
      if (reset || !(req_valid || expected_f.size() != 0) ||
          (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_right_half = '0;
      req_round_key  = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_corner_words();
      test_pipeline_fill();
      test_random_words();

      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_f.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
